// ===== sv/esds_dp_pkg.sv =====
`default_nettype none
package esds_dp_pkg;

   // field widths
   localparam int BYTE_W = 8;
   localparam int LEN_W = 28;
   localparam int LEN_COUNT_W = 2;

   // longest length field in bytes
   localparam int MAX_LENGTH_BYTES = 4;

   // bytes taken by the fixed headers of the descended descriptors
   localparam logic [LEN_W-1:0] ES_HEADER_BYTES = LEN_W'(3);
   localparam logic [LEN_W-1:0] DEC_CFG_HEADER_BYTES = LEN_W'(13);

   // descriptor tags
   localparam logic [BYTE_W-1:0] TAG_ES = 8'h03;
   localparam logic [BYTE_W-1:0] TAG_DEC_CFG = 8'h04;
   localparam logic [BYTE_W-1:0] TAG_DEC_SPECIFIC = 8'h05;

   // packed widths on the stream ports
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;

   // parser phases
   typedef enum logic [1:0] {
      PH_TAG  = 2'd0,
      PH_LEN  = 2'd1,
      PH_SKIP = 2'd2,
      PH_PAY  = 2'd3
   } phase_type;

endpackage : esds_dp_pkg
`default_nettype wire

// ===== sv/esds_descriptor_parser_unit.sv =====
// A payload byte shows on rsp in the cycle after its item is accepted.
// Throughput: one item per cycle; req_tready only drops while the result
// register is full and rsp_tready is low.
// Reset: synchronous, active high; returns the parser to the tag phase and
// clears the result register's valid flag.
`default_nettype none
module esds_descriptor_parser_unit
   import esds_dp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // [7:0] data_byte
   input  wire logic                   req_tlast,  // stream_last
   // result stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // [7:0] payload_byte, [35:8] payload_length,
                                                   // [39:36] zero
   output logic                        rsp_tuser,  // payload_first
   output logic                        rsp_tlast   // payload_last
);

   // parser state
   phase_type              phase_ff, phase_in;
   logic [BYTE_W-1:0]      tag_ff, tag_in;
   logic [LEN_W-1:0]       acc_ff, acc_in;
   logic [LEN_COUNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0]       remain_ff, remain_in;
   logic [LEN_W-1:0]       captured_ff, captured_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]      rsp_byte_ff;
   logic [LEN_W-1:0]       rsp_len_ff;
   logic                   rsp_first_ff;
   logic                   rsp_last_ff;

   logic                   accept;
   logic                   rsp_load;
   logic [BYTE_W-1:0]      data;
   logic [LEN_W-1:0]       acc_next;
   logic                   len_done;
   logic [LEN_W-1:0]       remain_dec;
   logic                   out_first;
   logic                   out_last;

   // handshake: take an item whenever the result register can move on
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign data       = req_tdata[BYTE_W-1:0];

   // shared step values
   assign acc_next   = {acc_ff[LEN_W-8:0], data[6:0]};
   assign len_done   = !data[7] || (count_ff == LEN_COUNT_W'(MAX_LENGTH_BYTES - 1));
   assign remain_dec = (remain_ff == '0) ? '0 : remain_ff - LEN_W'(1);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_TAG: begin
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (len_done) begin
                  if (tag_ff == TAG_ES || tag_ff == TAG_DEC_CFG) begin
                     phase_in = PH_SKIP;
                  end else if (acc_next == '0) begin
                     phase_in = PH_TAG;
                  end else if (tag_ff == TAG_DEC_SPECIFIC) begin
                     phase_in = PH_PAY;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP, PH_PAY: begin
               if (remain_dec == '0) begin
                  phase_in = PH_TAG;
               end
            end
            default: begin
               phase_in = PH_TAG;
            end
         endcase
         // end of stream abandons any open descriptor
         if (req_tlast) begin
            phase_in = PH_TAG;
         end
      end
   end

   // datapath registers and result fields
   always_comb begin
      tag_in      = tag_ff;
      acc_in      = acc_ff;
      count_in    = count_ff;
      remain_in   = remain_ff;
      captured_in = captured_ff;
      rsp_load    = 1'b0;
      out_first   = (remain_ff == captured_ff);
      out_last    = (remain_ff <= LEN_W'(1)) || req_tlast;
      if (accept) begin
         unique case (phase_ff)
            PH_TAG: begin
               tag_in   = data;
               acc_in   = '0;
               count_in = '0;
            end
            PH_LEN: begin
               acc_in = acc_next;
               if (len_done) begin
                  count_in = '0;
                  if (tag_ff == TAG_ES) begin
                     remain_in = ES_HEADER_BYTES;
                  end else if (tag_ff == TAG_DEC_CFG) begin
                     remain_in = DEC_CFG_HEADER_BYTES;
                  end else begin
                     remain_in = acc_next;
                     if (tag_ff == TAG_DEC_SPECIFIC) begin
                        captured_in = acc_next;
                     end
                  end
               end else begin
                  count_in = count_ff + LEN_COUNT_W'(1);
               end
            end
            PH_SKIP: begin
               remain_in = remain_dec;
            end
            PH_PAY: begin
               remain_in = remain_dec;
               rsp_load  = 1'b1;
            end
            default: begin
               remain_in = remain_dec;
            end
         endcase
         if (req_tlast) begin
            remain_in = '0;
            count_in  = '0;
         end
      end
   end

   // result valid: set on a payload byte, cleared when taken
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TAG;
         tag_ff       <= '0;
         acc_ff       <= '0;
         count_ff     <= '0;
         remain_ff    <= '0;
         captured_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tag_ff       <= tag_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         captured_ff  <= captured_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_byte_ff  <= data;
         rsp_len_ff   <= captured_ff;
         rsp_first_ff <= out_first;
         rsp_last_ff  <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - BYTE_W - LEN_W){1'b0}}, rsp_len_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_first_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_last_returns_to_tag: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (phase_ff == PH_TAG))
      else $error("parser not in tag phase after stream end");

   a_payload_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |-> (remain_ff != '0))
      else $error("payload phase with nothing left");

   a_count_only_in_len: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (phase_ff == PH_LEN))
      else $error("length byte count outside length phase");

   a_result_length_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_len_ff != '0))
      else $error("payload item carries zero length");

endmodule : esds_descriptor_parser_unit
`default_nettype wire

// ===== tb/sv/esds_payload_checker.sv =====
module esds_payload_checker
   import esds_dp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // [7:0] data_byte
   input  wire logic                   req_tlast,  // stream_last
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,  // [7:0] payload_byte, [35:8] payload_length
   input  wire logic                   rsp_tuser,  // payload_first
   input  wire logic                   rsp_tlast,  // payload_last
   output int                          mismatch_count,
   output int                          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAD_W = RSP_TDATA_W - BYTE_W - LEN_W;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  length;
      logic              first;
      logic              last;
   } payload_item_type;

   // parser state mirrored from the block
   phase_type              phase;
   logic [BYTE_W-1:0]      cur_tag;
   logic [LEN_W-1:0]       len_acc;
   logic [LEN_COUNT_W-1:0] len_count;
   logic [LEN_W-1:0]       remaining;
   logic [LEN_W-1:0]       body_length;

   payload_item_type payload_expected_q[$];
   payload_item_type want;
   logic [PAD_W-1:0] got_pad;

   // advance the parser by one byte, queue the payload item it yields
   task automatic advance_parser(input logic [BYTE_W-1:0] b, input logic last);
      logic [2:0]       seen;
      logic [LEN_W-1:0] len_next;
      payload_item_type item;
      case (phase)
         PH_TAG: begin
            cur_tag = b;
            len_acc = '0;
            len_count = '0;
            phase = PH_LEN;
         end
         PH_LEN: begin
            seen = {1'b0, len_count} + 3'd1;
            len_next = {len_acc[LEN_W-8:0], b[6:0]};
            len_acc = len_next;
            // the fourth length byte ends the field whatever its top bit
            if (!b[7] || seen >= 3'(MAX_LENGTH_BYTES)) begin
               len_count = '0;
               if (cur_tag == TAG_ES) begin
                  remaining = ES_HEADER_BYTES;
                  phase = PH_SKIP;
               end else if (cur_tag == TAG_DEC_CFG) begin
                  remaining = DEC_CFG_HEADER_BYTES;
                  phase = PH_SKIP;
               end else if (cur_tag == TAG_DEC_SPECIFIC) begin
                  body_length = len_next;
                  remaining = len_next;
                  phase = (len_next != '0) ? PH_PAY : PH_TAG;
               end else begin
                  remaining = len_next;
                  phase = (len_next != '0) ? PH_SKIP : PH_TAG;
               end
            end else begin
               len_count = seen[LEN_COUNT_W-1:0];
            end
         end
         PH_SKIP: begin
            if (remaining != '0) remaining = remaining - LEN_W'(1);
            if (remaining == '0) phase = PH_TAG;
         end
         default: begin
            item.data = b;
            item.length = body_length;
            item.first = (remaining == body_length);
            item.last = (remaining <= LEN_W'(1)) || last;
            payload_expected_q.push_back(item);
            if (remaining != '0) remaining = remaining - LEN_W'(1);
            if (remaining == '0) phase = PH_TAG;
         end
      endcase
      // end of stream drops any open descriptor
      if (last) begin
         phase = PH_TAG;
         remaining = '0;
         len_count = '0;
      end
   endtask

   // compare results first, then predict from the accepted input item
   always @(posedge clock) begin
      if (reset) begin
         phase = PH_TAG;
         cur_tag = '0;
         len_acc = '0;
         len_count = '0;
         remaining = '0;
         body_length = '0;
         payload_expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_pad = rsp_tdata[RSP_TDATA_W-1:BYTE_W+LEN_W];
            if (payload_expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result item: tdata %h tuser %b tlast %b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = payload_expected_q.pop_front();
               if (rsp_tdata[BYTE_W-1:0] !== want.data
                   || rsp_tdata[BYTE_W+LEN_W-1:BYTE_W] !== want.length
                   || got_pad !== '0
                   || rsp_tuser !== want.first
                   || rsp_tlast !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected byte %h len %h first %b last %b, %s%h",
                              want.data, want.length, want.first, want.last,
                              "got tdata ", rsp_tdata,
                              " tuser ", rsp_tuser, " tlast ", rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready)
            advance_parser(req_tdata[BYTE_W-1:0], req_tlast);
      end
      pending_count <= payload_expected_q.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import esds_dp_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEM_TARGET = 2000;
   localparam int HOLD_CYCLES = 400;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   int mismatch_count;
   int pending_count;
   int cycle_count = 0;
   int items_sent = 0;
   int send_idle_pct = 8;
   int recv_idle_pct = 60;
   logic hold_armed = 1'b0;
   logic hold_taken = 1'b0;
   int hold_left = 0;
   logic drained = 1'b0;

   // descriptor bytes of the stream being built
   logic [BYTE_W-1:0] stream_q[$];

   esds_descriptor_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   esds_payload_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_armed && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // offer one item, with random gaps, and wait for its acceptance
   task automatic send_item(input logic [BYTE_W-1:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_q.size(); i++)
         send_item(stream_q[i], i == stream_q.size() - 1);
   endtask

   // length field: minimal or padded size, sometimes a fourth byte with top bit set
   function automatic void push_length(int unsigned value);
      int unsigned nbytes;
      bit long_end;
      nbytes = 1;
      while (nbytes < MAX_LENGTH_BYTES && (value >> (7 * nbytes)) != 0) nbytes++;
      if ($urandom_range(3) == 0) nbytes = $urandom_range(MAX_LENGTH_BYTES, nbytes);
      long_end = (nbytes == MAX_LENGTH_BYTES) && ($urandom_range(2) == 0);
      for (int i = nbytes - 1; i >= 0; i--)
         stream_q.push_back({(i != 0) || long_end, 7'(value >> (7 * i))});
   endfunction

   // one well-formed descriptor with random content
   function automatic void push_descriptor(int depth);
      int unsigned pick;
      int unsigned len;
      logic [BYTE_W-1:0] tag;
      pick = $urandom_range(99);
      if (depth < 2 && pick < 20) begin
         stream_q.push_back(TAG_ES);
         push_length($urandom_range(60));
         repeat (3) stream_q.push_back(8'($urandom));
         repeat ($urandom_range(3, 1)) push_descriptor(depth + 1);
      end else if (depth < 2 && pick < 40) begin
         stream_q.push_back(TAG_DEC_CFG);
         push_length($urandom_range(60));
         repeat (13) stream_q.push_back(8'($urandom));
         repeat ($urandom_range(2, 1)) push_descriptor(depth + 1);
      end else if (pick < 80) begin
         stream_q.push_back(TAG_DEC_SPECIFIC);
         len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
         push_length(len);
         repeat (len) stream_q.push_back(8'($urandom));
      end else begin
         do tag = 8'($urandom);
         while (tag == TAG_ES || tag == TAG_DEC_CFG || tag == TAG_DEC_SPECIFIC);
         stream_q.push_back(tag);
         len = $urandom_range(5);
         push_length(len);
         repeat (len) stream_q.push_back(8'($urandom));
      end
   endfunction

   // mostly well-formed streams, some noise, some cut short
   function automatic void build_stream();
      int unsigned kind;
      int unsigned cut;
      stream_q.delete();
      kind = $urandom_range(99);
      if (kind < 8) begin
         repeat ($urandom_range(10, 1)) stream_q.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(3, 1)) push_descriptor(0);
         if (kind < 22) begin
            // huge payload length, body cut off by the stream end
            stream_q.push_back(TAG_DEC_SPECIFIC);
            push_length($urandom_range(32'h0FFF_FFFF, 32'h0000_0080));
            repeat ($urandom_range(3, 1)) stream_q.push_back(8'($urandom));
         end else if (kind < 32) begin
            cut = $urandom_range(stream_q.size(), 1);
            while (stream_q.size() > cut) void'(stream_q.pop_back());
         end
      end
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: single byte body, empty body, skipped tag, es header,
      // two-byte length ending on the stream end
      stream_q = '{8'h05, 8'h01, 8'h00,
                   8'h05, 8'h00,
                   8'h07, 8'h01, 8'hFF,
                   8'h03, 8'h00, 8'h11, 8'h22, 8'h33,
                   8'h05, 8'h80, 8'h02, 8'hAB, 8'hFF};
      send_stream();
      // directed: full four-byte length with top bit set, body truncated
      stream_q = '{8'h05, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A, 8'hC3};
      send_stream();

      // random streams through three idling modes
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end else if (items_sent >= ITEM_TARGET / 3) begin
            send_idle_pct = 60;
            recv_idle_pct <= 8;
         end
         if (!hold_armed && items_sent >= ITEM_TARGET / 6) hold_armed <= 1'b1;
         // pause the sender until every payload item has come back
         if (!drained && items_sent >= ITEM_TARGET / 2) begin
            drained = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_count != 0);
         end
         build_stream();
         send_stream();
      end
      req_tvalid <= 1'b0;

      // drain, then watch for stray results
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/esds_dp_pkg.sv
sv/esds_descriptor_parser_unit.sv
tb/sv/esds_payload_checker.sv
tb/sv/tb.sv
